@@ src/uvs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared constants, codes and control/status types of the unique value stack.
// ----------------------------------------------------------------------------
package uvs_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int MAX_RESULTS = 16;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int SHOW_W      = $clog2(MAX_RESULTS);

	localparam int CMD_W    = 3;
	localparam int VAL_W    = 32;
	localparam int POPN_W   = 8;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 5;

	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 40;
	localparam int M_TUSER_W = 3;

	// input word bit positions
	localparam int IN_CMD_LSB  = 0;
	localparam int IN_VAL_LSB  = IN_CMD_LSB + CMD_W;
	localparam int IN_POPN_LSB = IN_VAL_LSB + VAL_W;

	// output word bit positions
	localparam int OUT_OCC_LSB  = VAL_W;
	localparam int OUT_EVLD_BIT = STATUS_W;

	localparam logic [CMD_W-1:0] CMD_PUSH      = 3'd0;
	localparam logic [CMD_W-1:0] CMD_POP       = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_COUNT = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_UNTIL = 3'd3;
	localparam logic [CMD_W-1:0] CMD_REVERSE   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SHOW      = 3'd6;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DUP   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

	typedef enum logic [2:0] {
		RD_NONE, RD_WALK_UP, RD_WALK_DN, RD_TOP, RD_LO, RD_HI
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_NONE, WR_PUSH, WR_LO, WR_HI
	} wr_sel_t;

	typedef enum logic [2:0] {
		CNT_HOLD, CNT_INC, CNT_DEC, CNT_POPN, CNT_CLR, CNT_MATCH
	} cnt_op_t;

	typedef enum logic [2:0] {
		WALK_HOLD, WALK_ZERO, WALK_COUNT, WALK_INC, WALK_DEC
	} walk_op_t;

	typedef struct packed {
		logic                load_in;
		rd_sel_t             rd_sel;
		wr_sel_t             wr_sel;
		cnt_op_t             cnt_op;
		walk_op_t            walk_op;
		logic                rev_init;
		logic                rev_step;
		logic                tmp_save;
		logic                status_set;
		logic [STATUS_W-1:0] status_val;
		logic                show_clr;
		logic                out_top;
		logic                out_show;
	} dp_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             out_free;
		logic             match;
		logic             rd_pending;
		logic             walk_lt_count;
		logic             walk_nz;
		logic             count_zero;
		logic             count_full;
		logic             rev_more;
		logic             show_last;
	} dp_stat_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [VAL_W-1:0]    value;
		logic                evld;
		logic [OCC_W-1:0]    occ;
		logic                last;
	} res_t;

endpackage

@@ src/uvs_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_datapath
// Entry memory, occupancy and walk counters, compare logic and result register.
// ----------------------------------------------------------------------------
module uvs_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [uvs_pkg::S_TDATA_W-1:0]    s_tdata,
	input  uvs_pkg::dp_cmd_t                 cmd,
	input  logic                             m_tready,
	output uvs_pkg::dp_stat_t                stat,
	output logic                             out_vld,
	output uvs_pkg::res_t                    out_res
);

	logic [uvs_pkg::CMD_W-1:0]    cmd_q;
	logic [uvs_pkg::VAL_W-1:0]    val_q;
	logic [uvs_pkg::POPN_W-1:0]   popn_q;
	logic [uvs_pkg::VAL_W-1:0]    mem [uvs_pkg::STACK_DEPTH];
	logic [uvs_pkg::VAL_W-1:0]    rd_data_s1;
	logic [uvs_pkg::ADDR_W-1:0]   rd_addr_s1;
	logic                         rd_vld_s1;
	logic [uvs_pkg::CNT_W-1:0]    count_q;
	logic [uvs_pkg::CNT_W-1:0]    walk_q;
	logic [uvs_pkg::CNT_W-1:0]    lo_q;
	logic [uvs_pkg::CNT_W-1:0]    hi_q;
	logic [uvs_pkg::VAL_W-1:0]    tmp_q;
	logic [uvs_pkg::STATUS_W-1:0] status_q;
	logic [uvs_pkg::SHOW_W-1:0]   shown_q;
	logic                         out_vld_q;
	uvs_pkg::res_t                out_q;

	logic [uvs_pkg::CNT_W-1:0]  walk_m1;
	logic [uvs_pkg::CNT_W-1:0]  count_m1;
	logic                       rd_en;
	logic [uvs_pkg::ADDR_W-1:0] rd_addr;
	logic                       wr_en;
	logic [uvs_pkg::ADDR_W-1:0] wr_addr;
	logic [uvs_pkg::VAL_W-1:0]  wr_data;
	logic                       count_zero;
	logic                       show_last;

	assign walk_m1    = walk_q - uvs_pkg::CNT_W'(1);
	assign count_m1   = count_q - uvs_pkg::CNT_W'(1);
	assign count_zero = (count_q == '0);
	assign show_last  = (walk_q == uvs_pkg::CNT_W'(1)) ||
		(shown_q == uvs_pkg::SHOW_W'(uvs_pkg::MAX_RESULTS - 1));

	always_comb begin
		rd_en   = 1'b1;
		rd_addr = '0;
		case (cmd.rd_sel)
			uvs_pkg::RD_WALK_UP: rd_addr = walk_q[uvs_pkg::ADDR_W-1:0];
			uvs_pkg::RD_WALK_DN: rd_addr = walk_m1[uvs_pkg::ADDR_W-1:0];
			uvs_pkg::RD_TOP:     rd_addr = count_m1[uvs_pkg::ADDR_W-1:0];
			uvs_pkg::RD_LO:      rd_addr = lo_q[uvs_pkg::ADDR_W-1:0];
			uvs_pkg::RD_HI:      rd_addr = hi_q[uvs_pkg::ADDR_W-1:0];
			default:             rd_en   = 1'b0;
		endcase
	end

	always_comb begin
		wr_en   = 1'b1;
		wr_addr = '0;
		wr_data = val_q;
		case (cmd.wr_sel)
			uvs_pkg::WR_PUSH: wr_addr = count_q[uvs_pkg::ADDR_W-1:0];
			uvs_pkg::WR_LO: begin
				wr_addr = lo_q[uvs_pkg::ADDR_W-1:0];
				wr_data = rd_data_s1;
			end
			uvs_pkg::WR_HI: begin
				wr_addr = hi_q[uvs_pkg::ADDR_W-1:0];
				wr_data = tmp_q;
			end
			default: wr_en = 1'b0;
		endcase
	end

	// entry memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
			rd_addr_s1 <= rd_addr;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cmd_q  <= s_tdata[uvs_pkg::IN_CMD_LSB +: uvs_pkg::CMD_W];
			val_q  <= s_tdata[uvs_pkg::IN_VAL_LSB +: uvs_pkg::VAL_W];
			popn_q <= s_tdata[uvs_pkg::IN_POPN_LSB +: uvs_pkg::POPN_W];
		end
		if (cmd.tmp_save) begin
			tmp_q <= rd_data_s1;
		end
		if (cmd.status_set) begin
			status_q <= cmd.status_val;
		end
		if (cmd.out_top) begin
			out_q.status <= status_q;
			out_q.value  <= count_zero ? '0 : rd_data_s1;
			out_q.evld   <= !count_zero;
			out_q.occ    <= uvs_pkg::OCC_W'(count_q);
			out_q.last   <= 1'b1;
		end else if (cmd.out_show) begin
			out_q.status <= uvs_pkg::ST_OK;
			out_q.value  <= rd_data_s1;
			out_q.evld   <= 1'b1;
			out_q.occ    <= uvs_pkg::OCC_W'(count_q);
			out_q.last   <= show_last;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			count_q   <= '0;
			walk_q    <= '0;
			lo_q      <= '0;
			hi_q      <= '0;
			shown_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;

			case (cmd.cnt_op)
				uvs_pkg::CNT_INC: count_q <= count_q + uvs_pkg::CNT_W'(1);
				uvs_pkg::CNT_DEC: count_q <= count_m1;
				uvs_pkg::CNT_POPN: begin
					if (popn_q >= uvs_pkg::POPN_W'(count_q)) begin
						count_q <= '0;
					end else begin
						count_q <= count_q - uvs_pkg::CNT_W'(popn_q);
					end
				end
				uvs_pkg::CNT_CLR:   count_q <= '0;
				// stop just above the matching entry
				uvs_pkg::CNT_MATCH: count_q <= uvs_pkg::CNT_W'(rd_addr_s1) + uvs_pkg::CNT_W'(1);
				default: ;
			endcase

			case (cmd.walk_op)
				uvs_pkg::WALK_ZERO:  walk_q <= '0;
				uvs_pkg::WALK_COUNT: walk_q <= count_q;
				uvs_pkg::WALK_INC:   walk_q <= walk_q + uvs_pkg::CNT_W'(1);
				uvs_pkg::WALK_DEC:   walk_q <= walk_m1;
				default: ;
			endcase

			if (cmd.rev_init) begin
				lo_q <= '0;
				hi_q <= count_zero ? '0 : count_m1;
			end else if (cmd.rev_step) begin
				lo_q <= lo_q + uvs_pkg::CNT_W'(1);
				hi_q <= hi_q - uvs_pkg::CNT_W'(1);
			end

			if (cmd.show_clr) begin
				shown_q <= '0;
			end else if (cmd.out_show) begin
				shown_q <= shown_q + uvs_pkg::SHOW_W'(1);
			end

			if (cmd.out_top || cmd.out_show) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign stat.cmd           = cmd_q;
	assign stat.out_free      = !out_vld_q || m_tready;
	assign stat.match         = rd_vld_s1 && (rd_data_s1 == val_q);
	assign stat.rd_pending    = rd_vld_s1;
	assign stat.walk_lt_count = (walk_q < count_q);
	assign stat.walk_nz       = (walk_q != '0);
	assign stat.count_zero    = count_zero;
	assign stat.count_full    = (count_q == uvs_pkg::CNT_W'(uvs_pkg::STACK_DEPTH));
	assign stat.rev_more      = (lo_q < hi_q);
	assign stat.show_last     = show_last;

	assign out_vld = out_vld_q;
	assign out_res = out_q;

endmodule

@@ src/uvs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_ctrl
// Command sequencer: steps the datapath through search, walks and result words.
// ----------------------------------------------------------------------------
module uvs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  uvs_pkg::dp_stat_t stat,
	output uvs_pkg::dp_cmd_t  cmd
);

	typedef enum logic [12:0] {
		S_IDLE     = 13'b0000000000001,
		S_DISPATCH = 13'b0000000000010,
		S_SRCH     = 13'b0000000000100,
		S_PU       = 13'b0000000001000,
		S_REV_CHK  = 13'b0000000010000,
		S_REV_RLO  = 13'b0000000100000,
		S_REV_RHI  = 13'b0000001000000,
		S_REV_WLO  = 13'b0000010000000,
		S_REV_WHI  = 13'b0000100000000,
		S_SHOW_RD  = 13'b0001000000000,
		S_SHOW_OUT = 13'b0010000000000,
		S_TOP_RD   = 13'b0100000000000,
		S_TOP_OUT  = 13'b1000000000000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				cmd.status_set = 1'b1;
				cmd.status_val = uvs_pkg::ST_OK;
				state_d        = S_TOP_RD;
				case (stat.cmd)
					uvs_pkg::CMD_PUSH: begin
						cmd.walk_op = uvs_pkg::WALK_ZERO;
						state_d     = S_SRCH;
					end
					uvs_pkg::CMD_POP: begin
						if (stat.count_zero) begin
							cmd.status_val = uvs_pkg::ST_EMPTY;
						end else begin
							cmd.cnt_op = uvs_pkg::CNT_DEC;
						end
					end
					uvs_pkg::CMD_POP_COUNT: cmd.cnt_op = uvs_pkg::CNT_POPN;
					uvs_pkg::CMD_POP_UNTIL: begin
						cmd.walk_op = uvs_pkg::WALK_COUNT;
						state_d     = S_PU;
					end
					uvs_pkg::CMD_REVERSE: begin
						cmd.rev_init = 1'b1;
						state_d      = S_REV_CHK;
					end
					uvs_pkg::CMD_CLEAR: cmd.cnt_op = uvs_pkg::CNT_CLR;
					uvs_pkg::CMD_SHOW: begin
						if (stat.count_zero) begin
							cmd.status_val = uvs_pkg::ST_EMPTY;
						end else begin
							cmd.walk_op  = uvs_pkg::WALK_COUNT;
							cmd.show_clr = 1'b1;
							state_d      = S_SHOW_RD;
						end
					end
					default: ;
				endcase
			end
			// bottom-up compare, one read issued per cycle
			S_SRCH: begin
				if (stat.match) begin
					cmd.status_set = 1'b1;
					cmd.status_val = uvs_pkg::ST_DUP;
					state_d        = S_TOP_RD;
				end else if (stat.walk_lt_count) begin
					cmd.rd_sel  = uvs_pkg::RD_WALK_UP;
					cmd.walk_op = uvs_pkg::WALK_INC;
				end else if (!stat.rd_pending) begin
					if (stat.count_full) begin
						cmd.status_set = 1'b1;
						cmd.status_val = uvs_pkg::ST_FULL;
					end else begin
						cmd.wr_sel = uvs_pkg::WR_PUSH;
						cmd.cnt_op = uvs_pkg::CNT_INC;
					end
					state_d = S_TOP_RD;
				end
			end
			// top-down compare, first hit sets the new occupancy
			S_PU: begin
				if (stat.match) begin
					cmd.cnt_op = uvs_pkg::CNT_MATCH;
					state_d    = S_TOP_RD;
				end else if (stat.walk_nz) begin
					cmd.rd_sel  = uvs_pkg::RD_WALK_DN;
					cmd.walk_op = uvs_pkg::WALK_DEC;
				end else if (!stat.rd_pending) begin
					cmd.cnt_op = uvs_pkg::CNT_CLR;
					state_d    = S_TOP_RD;
				end
			end
			S_REV_CHK: state_d = stat.rev_more ? S_REV_RLO : S_TOP_RD;
			S_REV_RLO: begin
				cmd.rd_sel = uvs_pkg::RD_LO;
				state_d    = S_REV_RHI;
			end
			S_REV_RHI: begin
				cmd.rd_sel   = uvs_pkg::RD_HI;
				cmd.tmp_save = 1'b1;
				state_d      = S_REV_WLO;
			end
			S_REV_WLO: begin
				cmd.wr_sel = uvs_pkg::WR_LO;
				state_d    = S_REV_WHI;
			end
			S_REV_WHI: begin
				cmd.wr_sel   = uvs_pkg::WR_HI;
				cmd.rev_step = 1'b1;
				state_d      = S_REV_CHK;
			end
			S_SHOW_RD: begin
				cmd.rd_sel = uvs_pkg::RD_WALK_DN;
				state_d    = S_SHOW_OUT;
			end
			S_SHOW_OUT: begin
				if (stat.out_free) begin
					cmd.out_show = 1'b1;
					cmd.walk_op  = uvs_pkg::WALK_DEC;
					state_d      = stat.show_last ? S_IDLE : S_SHOW_RD;
				end
			end
			S_TOP_RD: begin
				cmd.rd_sel = uvs_pkg::RD_TOP;
				state_d    = S_TOP_OUT;
			end
			S_TOP_OUT: begin
				if (stat.out_free) begin
					cmd.out_top = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ src/unique_value_stack_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_value_stack_engine
// Bounded LIFO of signed 32-bit values with duplicate-rejecting push.
// ----------------------------------------------------------------------------
// usage:
//   s_* takes one command word at a time; s_tready is high only while the
//   engine waits for a command. m_* returns result words; show returns one
//   word per entry from the top down (m_tlast on the final one), all other
//   commands return a single word with m_tlast set.
//   pop, pop count, clear and an unused code go straight to the top read;
//   push walks the stored entries bottom-up, one memory read per cycle,
//   then reads the top (no walk on an empty stack); pop until walks
//   top-down to the first match, then reads the top; reverse swaps entry
//   pairs from the ends inward through the single read port of the entry
//   memory, then reads the top; show reads one entry per result word.
//   a new command can be accepted in the cycle after the last word is loaded.
//   the result register lets the next command be accepted while the last
//   word waits; while m_tready is low the engine holds a pending word and
//   stalls at the next word it would load.
//   after reset the stack is empty and no word is pending; no clearing pass
//   is needed, as no value above the occupancy reaches a result word.
// ----------------------------------------------------------------------------
module unique_value_stack_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// command, operand_value, pop_count
	input  logic [uvs_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// element_value, occupancy
	output logic [uvs_pkg::M_TDATA_W-1:0] m_tdata,
	// status, element_valid
	output logic [uvs_pkg::M_TUSER_W-1:0] m_tuser,
	output logic                          m_tlast
);

	uvs_pkg::dp_cmd_t  cmd;
	uvs_pkg::dp_stat_t stat;
	uvs_pkg::res_t     res;

	uvs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	uvs_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.m_tready (m_tready),
		.stat     (stat),
		.out_vld  (m_tvalid),
		.out_res  (res)
	);

	assign m_tdata = {{(uvs_pkg::M_TDATA_W - uvs_pkg::VAL_W - uvs_pkg::OCC_W){1'b0}},
		res.occ, res.value};
	assign m_tuser = {res.evld, res.status};
	assign m_tlast = res.last;

endmodule

@@ src/uvs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_checker
// Port-level checks on the result stream and command acceptance, bound to the top level.
// ----------------------------------------------------------------------------
module uvs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [uvs_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [uvs_pkg::M_TUSER_W-1:0] m_tuser,
	input logic                          m_tlast
);

	logic [uvs_pkg::OCC_W-1:0]    occ;
	logic [uvs_pkg::VAL_W-1:0]    value;
	logic [uvs_pkg::STATUS_W-1:0] status;
	logic                         evld;

	assign occ    = m_tdata[uvs_pkg::OUT_OCC_LSB +: uvs_pkg::OCC_W];
	assign value  = m_tdata[uvs_pkg::VAL_W-1:0];
	assign status = m_tuser[uvs_pkg::STATUS_W-1:0];
	assign evld   = m_tuser[uvs_pkg::OUT_EVLD_BIT];

	// a stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result word changed while stalled");

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> occ <= uvs_pkg::OCC_W'(uvs_pkg::STACK_DEPTH))
		else $error("occupancy beyond stack depth");

	// an entry is shown exactly when the stack holds something
	a_evld_occ: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (evld == (occ != '0)) && (evld || value == '0))
		else $error("element valid or value disagrees with occupancy");

	a_dup_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (status == uvs_pkg::ST_DUP || status == uvs_pkg::ST_FULL) |-> evld)
		else $error("duplicate or full reported on an empty stack");

	// a command is not taken while a show walk is mid-frame
	a_no_accept_mid_show: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !(s_tvalid && s_tready))
		else $error("command accepted before show frame finished");

endmodule

bind unique_value_stack_engine uvs_checker u_uvs_checker (.*);

@@ sim/tb_unique_value_stack_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_unique_value_stack_engine
// Self-checking bench for the duplicate-rejecting value stack.
// Commands go in on the s_* stream and are predicted against a local copy
// of the stack when accepted. Every m_* word is compared field by field with
// the oldest predicted word. Directed cases cover the empty stack and the
// value extremes. Random traffic follows in four phases (no idling, sender
// gaps, receiver stalls, both), and each phase starts by filling the stack.
// ----------------------------------------------------------------------------
module tb_unique_value_stack_engine;

	localparam logic [uvs_pkg::CMD_W-1:0] CMD_UNUSED = 3'd7;
	localparam int                        CYCLE_LIMIT = 400000;
	localparam int                        SETTLE_CYCLES = 60;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [uvs_pkg::S_TDATA_W-1:0] s_tdata = '0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [uvs_pkg::M_TDATA_W-1:0] m_tdata;
	logic [uvs_pkg::M_TUSER_W-1:0] m_tuser;
	logic                          m_tlast;

	// local copy of the stack, index 0 is the bottom
	logic [uvs_pkg::VAL_W-1:0] stack_mem [uvs_pkg::STACK_DEPTH];
	int                        depth_now = 0;
	uvs_pkg::res_t             expected_words[$];

	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	int  mismatch_count = 0;
	int  cmd_count = 0;
	int  word_count = 0;
	int  dup_hits = 0;
	int  full_hits = 0;
	int  show_words = 0;
	int  cycle_count = 0;
	uvs_pkg::res_t exp_w;

	unique_value_stack_engine DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	task automatic report_mismatch(input string field, input logic [39:0] got,
			input logic [39:0] want);
		$display("word %0d: %s is %0h, predicted %0h", word_count, field, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_words.size() == 0) begin
				report_mismatch("unexpected word", 40'(m_tdata), '0);
			end else begin
				exp_w = expected_words.pop_front();
				if (m_tuser[uvs_pkg::STATUS_W-1:0] !== exp_w.status)
					report_mismatch("status", 40'(m_tuser[uvs_pkg::STATUS_W-1:0]),
						40'(exp_w.status));
				if (m_tdata[uvs_pkg::VAL_W-1:0] !== exp_w.value)
					report_mismatch("element_value", 40'(m_tdata[uvs_pkg::VAL_W-1:0]),
						40'(exp_w.value));
				if (m_tuser[uvs_pkg::OUT_EVLD_BIT] !== exp_w.evld)
					report_mismatch("element_valid", 40'(m_tuser[uvs_pkg::OUT_EVLD_BIT]),
						40'(exp_w.evld));
				if (m_tdata[uvs_pkg::OUT_OCC_LSB +: uvs_pkg::OCC_W] !== exp_w.occ)
					report_mismatch("occupancy",
						40'(m_tdata[uvs_pkg::OUT_OCC_LSB +: uvs_pkg::OCC_W]),
						40'(exp_w.occ));
				if (m_tlast !== exp_w.last)
					report_mismatch("last", 40'(m_tlast), 40'(exp_w.last));
			end
			word_count++;
		end
	end

	function automatic uvs_pkg::res_t top_word(input logic [uvs_pkg::STATUS_W-1:0] st);
		uvs_pkg::res_t w;
		w.status = st;
		w.evld   = (depth_now > 0);
		w.value  = (depth_now > 0) ? stack_mem[depth_now-1] : '0;
		w.occ    = depth_now[uvs_pkg::OCC_W-1:0];
		w.last   = 1'b1;
		return w;
	endfunction

	function automatic bit holds_value(input logic [uvs_pkg::VAL_W-1:0] v);
		for (int i = 0; i < depth_now; i++)
			if (stack_mem[i] == v)
				return 1'b1;
		return 1'b0;
	endfunction

	// works out the result words of one accepted command and updates the copy
	task automatic stack_predict(input logic [uvs_pkg::CMD_W-1:0] cmd,
			input logic [uvs_pkg::VAL_W-1:0] val, input logic [uvs_pkg::POPN_W-1:0] cnt);
		uvs_pkg::res_t             w;
		logic [uvs_pkg::VAL_W-1:0] t;
		int                        n;
		case (cmd)
			uvs_pkg::CMD_PUSH: begin
				// duplicate check comes before the full check
				if (holds_value(val)) begin
					expected_words.push_back(top_word(uvs_pkg::ST_DUP));
					dup_hits++;
				end else if (depth_now >= uvs_pkg::STACK_DEPTH) begin
					expected_words.push_back(top_word(uvs_pkg::ST_FULL));
					full_hits++;
				end else begin
					stack_mem[depth_now] = val;
					depth_now++;
					expected_words.push_back(top_word(uvs_pkg::ST_OK));
				end
			end
			uvs_pkg::CMD_POP: begin
				if (depth_now == 0) begin
					expected_words.push_back(top_word(uvs_pkg::ST_EMPTY));
				end else begin
					depth_now--;
					expected_words.push_back(top_word(uvs_pkg::ST_OK));
				end
			end
			uvs_pkg::CMD_POP_COUNT: begin
				depth_now = (int'(cnt) >= depth_now) ? 0 : depth_now - int'(cnt);
				expected_words.push_back(top_word(uvs_pkg::ST_OK));
			end
			uvs_pkg::CMD_POP_UNTIL: begin
				while (depth_now > 0 && stack_mem[depth_now-1] != val)
					depth_now--;
				expected_words.push_back(top_word(uvs_pkg::ST_OK));
			end
			uvs_pkg::CMD_REVERSE: begin
				for (int i = 0; i < depth_now / 2; i++) begin
					t = stack_mem[i];
					stack_mem[i] = stack_mem[depth_now-1-i];
					stack_mem[depth_now-1-i] = t;
				end
				expected_words.push_back(top_word(uvs_pkg::ST_OK));
			end
			uvs_pkg::CMD_CLEAR: begin
				depth_now = 0;
				expected_words.push_back(top_word(uvs_pkg::ST_OK));
			end
			uvs_pkg::CMD_SHOW: begin
				if (depth_now == 0) begin
					expected_words.push_back(top_word(uvs_pkg::ST_EMPTY));
				end else begin
					n = (depth_now > uvs_pkg::MAX_RESULTS) ? uvs_pkg::MAX_RESULTS : depth_now;
					for (int k = 0; k < n; k++) begin
						w.status = uvs_pkg::ST_OK;
						w.evld   = 1'b1;
						w.value  = stack_mem[depth_now-1-k];
						w.occ    = depth_now[uvs_pkg::OCC_W-1:0];
						w.last   = (k == n - 1);
						expected_words.push_back(w);
						show_words++;
					end
				end
			end
			default: begin
				expected_words.push_back(top_word(uvs_pkg::ST_OK));
			end
		endcase
	endtask

	task automatic send_cmd(input logic [uvs_pkg::CMD_W-1:0] cmd,
			input logic [uvs_pkg::VAL_W-1:0] val, input logic [uvs_pkg::POPN_W-1:0] cnt);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		// command, operand_value, pop_count from the lowest bit up
		s_tdata  <= {5'b0, cnt, val, cmd};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		stack_predict(cmd, val, cnt);
		cmd_count++;
	endtask

	// sender holds off until every predicted word has come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_words.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [uvs_pkg::POPN_W-1:0] rand_cnt();
		return uvs_pkg::POPN_W'($urandom);
	endfunction

	function automatic logic [uvs_pkg::VAL_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return uvs_pkg::VAL_W'($urandom_range(0, 23)) - uvs_pkg::VAL_W'(12);
		else if (r < 85)
			return $urandom;
		case ($urandom_range(0, 3))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			default: return 32'hffff_ffff;
		endcase
	endfunction

	task automatic test_empty_stack();
		send_cmd(uvs_pkg::CMD_SHOW, $urandom, rand_cnt());
		send_cmd(uvs_pkg::CMD_POP, $urandom, rand_cnt());
		send_cmd(uvs_pkg::CMD_POP_COUNT, $urandom, 8'd3);
		send_cmd(uvs_pkg::CMD_POP_UNTIL, 32'd5, rand_cnt());
		send_cmd(uvs_pkg::CMD_REVERSE, $urandom, rand_cnt());
		send_cmd(CMD_UNUSED, $urandom, rand_cnt());
	endtask

	task automatic test_value_extremes();
		send_cmd(uvs_pkg::CMD_PUSH, 32'h8000_0000, 8'h00);
		send_cmd(uvs_pkg::CMD_PUSH, 32'h7fff_ffff, 8'hff);
		send_cmd(uvs_pkg::CMD_PUSH, 32'h0000_0000, 8'h00);
		send_cmd(uvs_pkg::CMD_PUSH, 32'hffff_ffff, 8'hff);
		send_cmd(uvs_pkg::CMD_PUSH, 32'h8000_0000, 8'h00);
		send_cmd(uvs_pkg::CMD_SHOW, 32'h0, 8'h0);
		send_cmd(uvs_pkg::CMD_REVERSE, 32'h0, 8'h0);
		send_cmd(uvs_pkg::CMD_SHOW, 32'h0, 8'h0);
		send_cmd(uvs_pkg::CMD_POP_COUNT, 32'h0, 8'd0);
		send_cmd(uvs_pkg::CMD_POP_UNTIL, 32'h0000_0000, 8'h0);
		send_cmd(uvs_pkg::CMD_POP, 32'h0, 8'h0);
		send_cmd(uvs_pkg::CMD_POP_COUNT, 32'hffff_ffff, 8'd255);
		send_cmd(uvs_pkg::CMD_CLEAR, 32'h0, 8'h0);
	endtask

	// clear, fill to the limit, then a new value (full) and a stored one (duplicate), then a show
	task automatic fill_to_full();
		logic [uvs_pkg::VAL_W-1:0] v;
		send_cmd(uvs_pkg::CMD_CLEAR, $urandom, rand_cnt());
		while (depth_now < uvs_pkg::STACK_DEPTH) begin
			v = pick_value();
			while (holds_value(v))
				v = $urandom;
			send_cmd(uvs_pkg::CMD_PUSH, v, rand_cnt());
		end
		v = $urandom;
		while (holds_value(v))
			v = $urandom;
		send_cmd(uvs_pkg::CMD_PUSH, v, rand_cnt());
		send_cmd(uvs_pkg::CMD_PUSH, stack_mem[$urandom_range(0, uvs_pkg::STACK_DEPTH - 1)],
			rand_cnt());
		send_cmd(uvs_pkg::CMD_SHOW, $urandom, rand_cnt());
	endtask

	task automatic random_item();
		int                         r;
		logic [uvs_pkg::VAL_W-1:0]  v;
		logic [uvs_pkg::POPN_W-1:0] c;
		r = $urandom_range(0, 99);
		v = $urandom;
		c = rand_cnt();
		if (r < 42) begin
			send_cmd(uvs_pkg::CMD_PUSH, pick_value(), c);
		end else if (r < 52) begin
			send_cmd(uvs_pkg::CMD_POP, v, c);
		end else if (r < 59) begin
			if ($urandom_range(0, 9) < 7)
				c = uvs_pkg::POPN_W'($urandom_range(0, 5));
			send_cmd(uvs_pkg::CMD_POP_COUNT, v, c);
		end else if (r < 67) begin
			// mostly stop at a stored value, sometimes run the stack dry
			if (depth_now > 0 && $urandom_range(0, 9) < 6)
				v = stack_mem[$urandom_range(0, depth_now - 1)];
			else
				v = pick_value();
			send_cmd(uvs_pkg::CMD_POP_UNTIL, v, c);
		end else if (r < 74) begin
			send_cmd(uvs_pkg::CMD_REVERSE, v, c);
		end else if (r < 77) begin
			send_cmd(uvs_pkg::CMD_CLEAR, v, c);
		end else if (r < 94) begin
			send_cmd(uvs_pkg::CMD_SHOW, v, c);
		end else begin
			send_cmd(CMD_UNUSED, v, c);
		end
	endtask

	task automatic test_traffic(input int idle_pct, input int stall_pct, input int n_items);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		fill_to_full();
		for (int i = 0; i < n_items; i++) begin
			random_item();
			if ($urandom_range(0, 99) < 2)
				wait_drained();
		end
		wait_drained();
	endtask

	initial begin
		for (int i = 0; i < uvs_pkg::STACK_DEPTH; i++)
			stack_mem[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_stack();
		test_value_extremes();
		wait_drained();
		test_traffic(0, 0, 58);
		test_traffic(51, 0, 58);
		test_traffic(0, 51, 58);
		test_traffic(30, 30, 58);

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("%0d commands sent, %0d result words checked (%0d from show)",
			cmd_count, word_count, show_words);
		$display("pushes rejected: %0d as duplicate, %0d on a full stack", dup_hits, full_hits);
		if (mismatch_count == 0 && expected_words.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0d mismatches, %0d words never came", mismatch_count,
				expected_words.size());
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
